### hw/rtl/length_prefixed_request_deframer_defines.svh
// Assertion macros for the request deframer core (lprd_core).
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define LPRD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define LPRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/lprd_pkg.sv
// Types and constants of the length-prefixed request deframer.
`timescale 1ns / 1ps
`default_nettype none

package lprd_pkg;

   localparam int BYTE_W      = 8;
   localparam int MSG_CFG_W   = 13;
   localparam int ARGS_W      = 8;
   localparam int STRLEN_W    = 13;
   localparam int CSR_INDEX_W = 1;

   localparam int MAX_BODY_BYTES_DEF = 4096;
   localparam int ARG_LIMIT          = 255;

   localparam logic [MSG_CFG_W-1:0] MAX_MSG_RESET  = 13'd4096;
   localparam logic [ARGS_W-1:0]    MAX_ARGS_RESET = 8'd200;

   localparam logic [STRLEN_W-1:0] STRLEN_SAT = '1;

   // rsp_tdata: arg_index, string_length, string_end, arg_count, error_code,
   // connection_closed, then zero fill to whole bytes
   localparam int RSP_FIELDS_W = ARGS_W + STRLEN_W + 1 + ARGS_W + 3 + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      PH_FRAMELEN,
      PH_COUNT,
      PH_STRLEN,
      PH_STRDATA,
      PH_SKIP,
      PH_CLOSED
   } phase_type;

   typedef enum logic [2:0] {
      ROLE_FRAME_LEN,
      ROLE_ARG_COUNT,
      ROLE_STR_LEN,
      ROLE_STR_DATA,
      ROLE_SKIPPED
   } role_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_TOO_LONG,
      ERR_SHORT,
      ERR_MANY_ARGS,
      ERR_LEN_OVERRUN,
      ERR_STR_OVERRUN,
      ERR_TRAILING
   } err_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_MESSAGE_BYTES,
      CSR_MAX_ARGUMENTS
   } csr_type;

   typedef struct packed {
      role_type                byte_role;
      logic [ARGS_W-1:0]       arg_index;
      logic [STRLEN_W-1:0]     string_length;
      logic                    string_end;
      logic                    message_done;
      logic [ARGS_W-1:0]       arg_count;
      err_type                 error_code;
      logic                    connection_closed;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/lprd_core.sv
// Per-byte frame decoder: parse state registers and the tagging logic.
`timescale 1ns / 1ps
`default_nettype none

`include "length_prefixed_request_deframer_defines.svh"

module lprd_core #(
   parameter int MAX_BODY_BYTES = lprd_pkg::MAX_BODY_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic [lprd_pkg::BYTE_W-1:0]    rx_byte,
   input  wire logic [lprd_pkg::MSG_CFG_W-1:0] max_msg_cfg,
   input  wire logic [lprd_pkg::ARGS_W-1:0]    arg_max_cfg,
   output lprd_pkg::result_type                step_res
);

   localparam int BodyW = $clog2(MAX_BODY_BYTES + 1);

   lprd_pkg::phase_type                phase_ff, phase_in;
   logic [1:0]                         fld_cnt_ff, fld_cnt_in;
   logic [31:0]                        fld_shift_ff, fld_shift_in;
   logic [BodyW-1:0]                   body_ff, body_in;
   logic [lprd_pkg::ARGS_W-1:0]        args_ff, args_in;
   logic [lprd_pkg::ARGS_W-1:0]        cur_arg_ff, cur_arg_in;
   logic [BodyW-1:0]                   str_ff, str_in;
   lprd_pkg::err_type                  pending_ff, pending_in;
   logic                               closed_ff, closed_in;

   logic [31:0]                        body_lim;
   logic [31:0]                        arg_lim;
   logic                               active;
   logic                               last;
   logic                               fld_done;
   logic [31:0]                        word;
   logic [BodyW-1:0]                   body_dec;
   logic [BodyW-1:0]                   str_dec;
   logic [lprd_pkg::ARGS_W-1:0]        args_dec;
   logic                               report;
   lprd_pkg::err_type                  report_code;
   logic                               defer;
   lprd_pkg::err_type                  defer_code;
   logic                               msg_ok;
   logic                               arg_fin;
   logic                               go_count;
   logic                               go_strlen;
   logic                               go_strdata;

   assign body_lim = (32'(max_msg_cfg) < 32'(MAX_BODY_BYTES)) ?
                     32'(max_msg_cfg) : 32'(MAX_BODY_BYTES);
   assign arg_lim  = (32'(arg_max_cfg) < 32'(lprd_pkg::ARG_LIMIT)) ?
                     32'(arg_max_cfg) : 32'(lprd_pkg::ARG_LIMIT);

   // Decode: what this byte completes and where it sends the frame
   always_comb begin
      active     = (phase_ff != lprd_pkg::PH_FRAMELEN) && (phase_ff != lprd_pkg::PH_CLOSED);
      body_dec   = (body_ff != '0) ? body_ff - BodyW'(1) : '0;
      str_dec    = (str_ff != '0) ? str_ff - BodyW'(1) : '0;
      args_dec   = args_ff - 8'd1;
      last       = active && (body_dec == '0);
      fld_done   = (fld_cnt_ff == 2'd3);
      word       = fld_shift_ff | (32'(rx_byte) << {fld_cnt_ff, 3'b000});
      report      = 1'b0;
      report_code = lprd_pkg::ERR_NONE;
      defer       = 1'b0;
      defer_code  = lprd_pkg::ERR_NONE;
      msg_ok      = 1'b0;
      arg_fin     = 1'b0;
      go_count    = 1'b0;
      go_strlen   = 1'b0;
      go_strdata  = 1'b0;
      unique case (phase_ff)
         lprd_pkg::PH_FRAMELEN: begin
            if (fld_done) begin
               if (word > body_lim) begin
                  report      = 1'b1;
                  report_code = lprd_pkg::ERR_TOO_LONG;
               end else if (word == '0) begin
                  report      = 1'b1;
                  report_code = lprd_pkg::ERR_SHORT;
               end else begin
                  go_count = 1'b1;
               end
            end
         end
         lprd_pkg::PH_COUNT: begin
            if (fld_done) begin
               if (word > arg_lim) begin
                  if (last) begin
                     report      = 1'b1;
                     report_code = lprd_pkg::ERR_MANY_ARGS;
                  end else begin
                     defer      = 1'b1;
                     defer_code = lprd_pkg::ERR_MANY_ARGS;
                  end
               end else if (word == '0) begin
                  if (last) begin
                     msg_ok = 1'b1;
                  end else begin
                     defer      = 1'b1;
                     defer_code = lprd_pkg::ERR_TRAILING;
                  end
               end else if (last) begin
                  report      = 1'b1;
                  report_code = lprd_pkg::ERR_LEN_OVERRUN;
               end else begin
                  go_strlen = 1'b1;
               end
            end else if (last) begin
               report      = 1'b1;
               report_code = lprd_pkg::ERR_SHORT;
            end
         end
         lprd_pkg::PH_STRLEN: begin
            if (fld_done) begin
               if (word > 32'(body_dec)) begin
                  if (last) begin
                     report      = 1'b1;
                     report_code = lprd_pkg::ERR_STR_OVERRUN;
                  end else begin
                     defer      = 1'b1;
                     defer_code = lprd_pkg::ERR_STR_OVERRUN;
                  end
               end else if (word == '0) begin
                  arg_fin = 1'b1;
               end else begin
                  go_strdata = 1'b1;
               end
            end else if (last) begin
               report      = 1'b1;
               report_code = lprd_pkg::ERR_LEN_OVERRUN;
            end
         end
         lprd_pkg::PH_STRDATA: begin
            arg_fin = (str_dec == '0);
         end
         lprd_pkg::PH_SKIP: begin
            if (last) begin
               report      = 1'b1;
               report_code = pending_ff;
            end
         end
         default: begin
         end
      endcase
      // A finished string either closes the request or opens the next length
      if (arg_fin) begin
         if (args_dec == '0) begin
            if (last) begin
               msg_ok = 1'b1;
            end else begin
               defer      = 1'b1;
               defer_code = lprd_pkg::ERR_TRAILING;
            end
         end else if (last) begin
            report      = 1'b1;
            report_code = lprd_pkg::ERR_LEN_OVERRUN;
         end else begin
            go_strlen = 1'b1;
         end
      end
   end

   // Next state
   always_comb begin
      priority if (report) begin
         phase_in = lprd_pkg::PH_CLOSED;
      end else if (defer) begin
         phase_in = lprd_pkg::PH_SKIP;
      end else if (msg_ok) begin
         phase_in = lprd_pkg::PH_FRAMELEN;
      end else if (go_strlen) begin
         phase_in = lprd_pkg::PH_STRLEN;
      end else if (go_count) begin
         phase_in = lprd_pkg::PH_COUNT;
      end else if (go_strdata) begin
         phase_in = lprd_pkg::PH_STRDATA;
      end else begin
         phase_in = phase_ff;
      end
   end

   // Outputs and datapath updates
   always_comb begin
      step_res     = '0;
      fld_cnt_in   = fld_cnt_ff;
      fld_shift_in = fld_shift_ff;
      body_in      = active ? body_dec : body_ff;
      args_in      = args_ff;
      cur_arg_in   = cur_arg_ff;
      str_in       = str_ff;
      unique case (phase_ff)
         lprd_pkg::PH_FRAMELEN: begin
            step_res.byte_role = lprd_pkg::ROLE_FRAME_LEN;
            fld_cnt_in   = fld_cnt_ff + 2'd1;
            fld_shift_in = fld_done ? '0 : word;
            if (go_count) begin
               body_in = word[BodyW-1:0];
            end
         end
         lprd_pkg::PH_COUNT: begin
            step_res.byte_role = lprd_pkg::ROLE_ARG_COUNT;
            fld_cnt_in   = fld_cnt_ff + 2'd1;
            fld_shift_in = fld_done ? '0 : word;
            if (fld_done) begin
               cur_arg_in = '0;
            end
            if (go_strlen) begin
               args_in = word[lprd_pkg::ARGS_W-1:0];
            end
         end
         lprd_pkg::PH_STRLEN: begin
            step_res.byte_role = lprd_pkg::ROLE_STR_LEN;
            step_res.arg_index = cur_arg_ff;
            fld_cnt_in   = fld_cnt_ff + 2'd1;
            fld_shift_in = fld_done ? '0 : word;
            if (fld_done) begin
               step_res.string_length = (word > 32'(lprd_pkg::STRLEN_SAT)) ?
                                        lprd_pkg::STRLEN_SAT :
                                        word[lprd_pkg::STRLEN_W-1:0];
            end
            if (go_strdata) begin
               str_in = word[BodyW-1:0];
            end
         end
         lprd_pkg::PH_STRDATA: begin
            step_res.byte_role = lprd_pkg::ROLE_STR_DATA;
            step_res.arg_index = cur_arg_ff;
            str_in = str_dec;
         end
         default: begin
            step_res.byte_role = lprd_pkg::ROLE_SKIPPED;
         end
      endcase
      if (arg_fin) begin
         step_res.string_end = 1'b1;
         args_in      = args_dec;
         cur_arg_in   = cur_arg_ff + 8'd1;
         fld_cnt_in   = '0;
         fld_shift_in = '0;
         if (msg_ok) begin
            step_res.arg_count = cur_arg_ff + 8'd1;
         end
      end
      step_res.message_done      = msg_ok;
      step_res.error_code        = report ? report_code : lprd_pkg::ERR_NONE;
      closed_in                  = closed_ff | report;
      step_res.connection_closed = closed_in;
      pending_in                 = defer ? defer_code : pending_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lprd_pkg::PH_FRAMELEN;
         fld_cnt_ff   <= '0;
         fld_shift_ff <= '0;
         body_ff      <= '0;
         args_ff      <= '0;
         cur_arg_ff   <= '0;
         str_ff       <= '0;
         pending_ff   <= lprd_pkg::ERR_NONE;
         closed_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         fld_cnt_ff   <= fld_cnt_in;
         fld_shift_ff <= fld_shift_in;
         body_ff      <= body_in;
         args_ff      <= args_in;
         cur_arg_ff   <= cur_arg_in;
         str_ff       <= str_in;
         pending_ff   <= pending_in;
         closed_ff    <= closed_in;
      end
   end

   `LPRD_ASSERT_NEXT(a_closed_sticky, clock, reset, closed_ff, closed_ff,
      "connection reopened after an error")
   `LPRD_ASSERT_IMPLIES(a_closed_phase, clock, reset, 1'b1,
      (phase_ff == lprd_pkg::PH_CLOSED) == closed_ff,
      "closed flag and closed phase disagree")
   `LPRD_ASSERT_IMPLIES(a_skip_has_error, clock, reset, phase_ff == lprd_pkg::PH_SKIP,
      pending_ff != lprd_pkg::ERR_NONE, "skipping a frame with no pending error")
   `LPRD_ASSERT_IMPLIES(a_string_in_body, clock, reset, phase_ff == lprd_pkg::PH_STRDATA,
      (str_ff != '0) && (str_ff <= body_ff), "string runs past the frame body")
   `LPRD_ASSERT_IMPLIES(a_done_clean, clock, reset, advance && step_res.message_done,
      (step_res.error_code == lprd_pkg::ERR_NONE) && !step_res.connection_closed,
      "request completed together with an error")

endmodule

`default_nettype wire

### hw/rtl/length_prefixed_request_deframer.sv
// Top level of the length-prefixed request deframer: stream stages and registers.
// Path: a req transfer loads the input stage (in_byte_ff), and the parse step then
// writes the result stage (out_valid_ff, out_res_ff) that drives the rsp outputs.
// Throughput: one byte per cycle unless rsp stalls; one parse-state step per byte.
// req_tready stays high while the result register is empty or being drained.
// Reset clears the parse state and both stages, and loads max_message_bytes = 4096
// and max_arguments = 200; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_request_deframer #(
   parameter int MAX_BODY_BYTES = lprd_pkg::MAX_BODY_BYTES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: rx_byte[7:0]
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [lprd_pkg::BYTE_W-1:0]       req_tdata,
   // rsp_tdata: arg_index[7:0], string_length[20:8], string_end[21],
   // arg_count[29:22], error_code[32:30], connection_closed[33], zero[39:34]
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [lprd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: byte_role[2:0]
   output      logic [2:0]                        rsp_tuser,
   // rsp_tlast: message_done
   output      logic                              rsp_tlast,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [lprd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lprd_pkg::MSG_CFG_W-1:0]    csr_data
);

   logic                             in_valid_ff, in_valid_in;
   logic [lprd_pkg::BYTE_W-1:0]      in_byte_ff, in_byte_in;
   logic                             out_valid_ff, out_valid_in;
   lprd_pkg::result_type             out_res_ff, out_res_in;
   logic [lprd_pkg::MSG_CFG_W-1:0]   max_msg_ff, max_msg_in;
   logic [lprd_pkg::ARGS_W-1:0]      arg_max_ff, arg_max_in;

   logic                             out_free;
   logic                             advance;
   logic                             req_xfer;
   lprd_pkg::result_type             step_res;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in   = req_xfer ? req_tdata : in_byte_ff;
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_res_in   = advance ? step_res : out_res_ff;
   end

   always_comb begin
      max_msg_in = max_msg_ff;
      arg_max_in = arg_max_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lprd_pkg::CSR_MAX_MESSAGE_BYTES: max_msg_in = csr_data;
            lprd_pkg::CSR_MAX_ARGUMENTS:     arg_max_in = csr_data[lprd_pkg::ARGS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_msg_ff   <= lprd_pkg::MAX_MSG_RESET;
         arg_max_ff   <= lprd_pkg::MAX_ARGS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         max_msg_ff   <= max_msg_in;
         arg_max_ff   <= arg_max_in;
      end
   end

   // Payload stages hold while stalled
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_res_ff <= out_res_in;
   end

   lprd_core #(
      .MAX_BODY_BYTES (MAX_BODY_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .rx_byte     (in_byte_ff),
      .max_msg_cfg (max_msg_ff),
      .arg_max_cfg (arg_max_ff),
      .step_res    (step_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.byte_role;
   assign rsp_tlast  = out_res_ff.message_done;
   assign rsp_tdata  = {{(lprd_pkg::RSP_DATA_W - lprd_pkg::RSP_FIELDS_W){1'b0}},
                        out_res_ff.connection_closed,
                        out_res_ff.error_code,
                        out_res_ff.arg_count,
                        out_res_ff.string_end,
                        out_res_ff.string_length,
                        out_res_ff.arg_index};

endmodule

`default_nettype wire
